// ===== hw/rtl/waveform_min_max_rms_decimator_defines.svh =====
// Assertion macros for the decimator RTL.
`ifndef WAVEFORM_MIN_MAX_RMS_DECIMATOR_DEFINES_SVH
`define WAVEFORM_MIN_MAX_RMS_DECIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/wmrd_pkg.sv =====
package wmrd_pkg;
	localparam int unsigned MaxWindow = 262144;
	localparam int unsigned SampleBits = 16;
	localparam int unsigned ResW = 28;
	localparam int unsigned PW = 29;
	localparam int unsigned CntW = 19;
	localparam int unsigned SumW = 48;
	localparam int unsigned FrmW = 32;
	localparam logic [PW-1:0] PLo = PW'(1000);
	localparam logic [PW-1:0] PHi = PW'(MaxWindow * 1000);
	localparam logic [SumW-1:0] SumLimit = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic div_step;
		logic start_sqrt;
		logic sqrt_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_last;
		logic sqrt_last;
	} sts_t;

	typedef struct packed {
		logic [FrmW-1:0] frame_number;
		logic [7:0] min_level;
		logic [7:0] max_level;
		logic [6:0] rms_level;
	} result_t;

	function automatic logic [7:0] level8(input logic signed [SampleBits-1:0] v);
		logic [SampleBits-1:0] off;
		logic [SampleBits+7:0] prod;
		off = SampleBits'(v) ^ {1'b1, {(SampleBits-1){1'b0}}};
		prod = {8'd0, off} * (SampleBits+8)'(255);
		return prod[SampleBits+7:SampleBits];
	endfunction
endpackage

// ===== hw/rtl/waveform_min_max_rms_decimator.sv =====
// A sample that closes a frame is followed by the divide steps, the square
// root steps and a load into the output register, which then offers the result.
// Throughput: one sample per cycle while idle; a closing sample holds the input
// through the divide, square root and load, longer while a result waits.
// Reset: arst_n asynchronous; registers go to 1 ms and 44100 Hz, state clears.
module waveform_min_max_rms_decimator (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [17:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // left_sample, right_sample
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata // frame_number, min_level, max_level, rms_level, pad
);
	import wmrd_pkg::*;
	cmd_t cmd;
	sts_t sts;
	result_t res;
	logic valid_q;
	logic [54:0] data_q;

	wmrd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.out_busy(valid_q && !m_axis_tready), .sts(sts),
		.in_ready(s_axis_tready), .cmd(cmd)
	);

	wmrd_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index[0]),
		.cfg_data(cfg_data), .left_sample(s_axis_tdata[15:0]),
		.right_sample(s_axis_tdata[31:16]), .cmd(cmd), .sts(sts), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.load_out) valid_q <= 1'b1;
		else if (m_axis_tready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			data_q <= {res.rms_level, res.max_level, res.min_level, res.frame_number};
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {1'b0, data_q};
endmodule

// ===== hw/rtl/wmrd_ctrl.sv =====
`include "waveform_min_max_rms_decimator_defines.svh"
module wmrd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_busy,
	input wmrd_pkg::sts_t sts,
	output logic in_ready,
	output wmrd_pkg::cmd_t cmd
);
	import wmrd_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.close) begin
						cmd.start_div = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.start_sqrt = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_IMPL(a_ready_idle, in_ready, state_q == ST_IDLE, "ready outside idle")
	`ASSERT_NEXT(a_close_div, cmd.start_div, state_q == ST_DIV, "close without divide")
	`ASSERT_IMPL(a_load_free, cmd.load_out, !out_busy, "overwrite of pending result")
endmodule

// ===== hw/rtl/wmrd_dpath.sv =====
module wmrd_dpath (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [17:0] cfg_data,
	input logic signed [15:0] left_sample,
	input logic signed [15:0] right_sample,
	input wmrd_pkg::cmd_t cmd,
	output wmrd_pkg::sts_t sts,
	output wmrd_pkg::result_t res
);
	import wmrd_pkg::*;
	localparam int unsigned DivSteps = SumW;
	logic [10:0] mspp_q;
	logic [17:0] srate_q;
	logic [10:0] mspp_d;
	logic [17:0] srate_d;
	logic [PW-1:0] p_q;
	logic [ResW-1:0] residue_q;
	logic [FrmW-1:0] frame_q;
	logic [CntW-1:0] count_q;
	logic [SumW-1:0] sum_q;
	logic signed [SampleBits-1:0] min_q, max_q;
	logic [SumW-1:0] quo_q;
	logic [CntW:0] rem_q;
	logic [CntW-1:0] dcnt_q;
	logic [5:0] step_q;
	logic [SumW-1:0] sq_v_q;
	logic [SumW-1:0] root_q;
	logic [SumW-1:0] bit_q;
	logic [FrmW-1:0] ofrm_q;
	logic [7:0] omin_q, omax_q;
	logic [28:0] prod;
	logic signed [SampleBits:0] lr;
	logic signed [SampleBits-1:0] m;
	logic [2*SampleBits-1:0] sq;
	logic [SumW:0] sum_add;
	logic [SumW-1:0] sum_base;
	logic first;
	logic close;
	logic [CntW:0] rem_sh;
	logic div_ge;
	logic [SumW-1:0] quo_nx;
	logic [SumW-1:0] trial;
	logic [30:0] rl;

	assign mspp_d = (cfg_we && !cfg_index) ? cfg_data[10:0] : mspp_q;
	assign srate_d = (cfg_we && cfg_index) ? cfg_data : srate_q;
	assign prod = 29'(mspp_d) * 29'(srate_d);
	assign lr = 17'(left_sample) + 17'(right_sample);
	assign m = lr[SampleBits:1];
	assign sq = 32'($signed(m) * $signed(m));
	assign close = {1'b0, residue_q} >= p_q;
	assign sts.close = close;
	assign first = close || count_q == '0;
	assign sum_base = close ? '0 : sum_q;
	assign sum_add = {1'b0, sum_base} + (SumW+1)'(sq);
	assign sts.div_last = step_q == 6'(DivSteps - 1);
	assign sts.sqrt_last = bit_q[1:0] != 2'b00 || bit_q == '0;
	assign rem_sh = {rem_q[CntW-1:0], quo_q[SumW-1]};
	assign div_ge = rem_sh >= {1'b0, dcnt_q};
	assign quo_nx = {quo_q[SumW-2:0], div_ge};
	assign trial = sq_v_q - (root_q + bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mspp_q <= 11'd1;
			srate_q <= 18'd44100;
			p_q <= PW'(44100);
			residue_q <= '0;
			frame_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			step_q <= '0;
		end else begin
			mspp_q <= mspp_d;
			srate_q <= srate_d;
			if (prod < PLo) p_q <= PLo;
			else if (prod > PHi) p_q <= PHi;
			else p_q <= prod;
			if (cmd.accept) begin
				residue_q <= (close ? residue_q - ResW'(p_q) : residue_q) + ResW'(1000);
				if (close) frame_q <= frame_q + 1'b1;
				count_q <= close ? CntW'(1) : (&count_q ? count_q : count_q + 1'b1);
				sum_q <= sum_add[SumW] ? SumLimit : sum_add[SumW-1:0];
			end
			if (cmd.start_div) step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (first || m < min_q) min_q <= m;
			if (first || (m > max_q && !(m < min_q))) max_q <= m;
		end
		if (cmd.start_div) begin
			quo_q <= sum_q;
			rem_q <= '0;
			dcnt_q <= count_q;
			ofrm_q <= frame_q;
			omin_q <= level8(min_q);
			omax_q <= level8(max_q);
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? rem_sh - {1'b0, dcnt_q} : rem_sh;
			quo_q <= quo_nx;
		end
		if (cmd.start_sqrt) begin
			sq_v_q <= quo_nx;
			root_q <= '0;
			bit_q <= SumW'(1) << (SumW - 2);
		end else if (cmd.sqrt_step && bit_q != '0) begin
			if (sq_v_q >= root_q + bit_q) begin
				sq_v_q <= trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rl = (31'(root_q) * 31'(127)) >> (SampleBits - 1);
	assign res.frame_number = ofrm_q;
	assign res.min_level = omin_q;
	assign res.max_level = omax_q;
	assign res.rms_level = (rl > 31'd127) ? 7'd127 : rl[6:0];
endmodule
